>>> design/cpts_pkg.sv
package cpts_pkg;

  // Default sizes of the slot table.
  localparam int unsigned SlotsDef      = 64;
  localparam int unsigned PidBitsDef    = 16;
  localparam int unsigned CreditBitsDef = 32;

  // Fixed field widths.
  localparam int unsigned FuncW      = 3;
  localparam int unsigned PidInW     = 16;
  localparam int unsigned PrioW      = 8;
  localparam int unsigned HoldW      = 8;
  localparam int unsigned SlotOutW   = 6;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 32;

  // Request opcodes.
  typedef enum logic [FuncW-1:0] {
    FN_ADD       = 3'd0,
    FN_REMOVE    = 3'd1,
    FN_BLOCK     = 3'd2,
    FN_UNBLOCK   = 3'd3,
    FN_TICK      = 3'd4,
    FN_SCHEDULE  = 3'd5,
    FN_HOLD_UP   = 3'd6,
    FN_HOLD_DOWN = 3'd7
  } func_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_e;

endpackage

>>> design/cpts_slot_ram.sv
module cpts_slot_ram #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned ROW_BITS = 64,
  parameter logic [ROW_BITS-1:0] INIT_ROW0 = '0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  logic [ROW_BITS-1:0]      wdata_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output logic [$clog2(SLOTS)-1:0] raddr_o,
  output logic [ROW_BITS-1:0]      rdata_o
);

  localparam int unsigned IdxW = $clog2(SLOTS);

  logic [ROW_BITS-1:0] mem_q [SLOTS];
  logic [ROW_BITS-1:0] rdata_q;
  logic [IdxW-1:0]     raddr_q;
  logic                init0_q;

  // Row 0 holds a live entry out of reset; until it is first written its
  // contents are supplied from the reset pattern.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init0_q <= 1'b1;
    end else if (we_i && (waddr_i == '0)) begin
      init0_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
    raddr_q <= raddr_i;
  end

  assign raddr_o = raddr_q;
  assign rdata_o = (init0_q && (raddr_q == '0)) ? INIT_ROW0 : rdata_q;

endmodule

>>> design/credit_priority_task_scheduler_top.sv
// Hold up, hold down and a tick that does not reschedule read and write only the running slot's
// row; add, remove and unblock scan the table up to their slot; schedule and a tick that
// reschedules scan the whole table, block scans for its task and then the whole table. One
// request at a time; the scan over the slot RAM (one read, one write port, one row per cycle) sets the pace.
// rst_ni clears the control state asynchronously; after reset slot 0 is live with priority 1
// and the RAM needs no clearing pass.
module credit_priority_task_scheduler_top #(
  parameter int unsigned SLOTS       = cpts_pkg::SlotsDef,
  parameter int unsigned PID_BITS    = cpts_pkg::PidBitsDef,
  parameter int unsigned CREDIT_BITS = cpts_pkg::CreditBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata, low bit up: task_pid[15:0], priority_req[23:16].
  input  logic [cpts_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: func[2:0].
  input  logic [cpts_pkg::FuncW-1:0]    s_axis_tuser_i,
  // Result channel.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata, low bit up: running_slot[5:0], running_pid[21:6], switched[22],
  // status[24:23], zero fill[31:25].
  output logic [cpts_pkg::OutDataW-1:0] m_axis_tdata_o
);

  import cpts_pkg::*;

  localparam int unsigned IdxW     = $clog2(SLOTS);
  localparam int unsigned CB       = CREDIT_BITS;
  localparam int unsigned PrioLo   = PID_BITS;
  localparam int unsigned CredLo   = PID_BITS + PrioW;
  localparam int unsigned HoldLo   = CredLo + CB;
  localparam int unsigned RowBits  = HoldLo + HoldW;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(SLOTS - 1);
  localparam logic [CB-1:0] CreditMax = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] CreditMin = {1'b1, {(CB-1){1'b0}}};
  localparam logic [RowBits-1:0] InitRow0 =
    {{HoldW{1'b0}}, {CB{1'b0}}, PrioW'(1), {PID_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_START, S_SCAN, S_ROW_RD, S_ROW_OP,
    S_PICK_RD, S_PICK_WR, S_FINAL_RD, S_FINAL
  } state_e;

  // What the slot scan is looking for.
  typedef enum logic [1:0] {
    M_FREE, M_FIND, M_SCHED
  } mode_e;

  state_e               state_q;
  mode_e                mode_q;
  func_e                func_q;
  status_e              status_q;
  logic [PID_BITS-1:0]  pid_q;
  logic [PrioW-1:0]     prio_q;
  logic [IdxW-1:0]      run_q;
  logic [IdxW-1:0]      before_q;
  logic [IdxW-1:0]      idx_q;
  logic [IdxW-1:0]      pick_q;
  logic signed [CB-1:0] best_q;
  logic                 found_q;
  logic [SLOTS-1:0]     valid_q;
  logic [SLOTS-1:0]     blocked_q;
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;

  // Slot RAM port.
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [RowBits-1:0]   mem_wdata;
  logic [IdxW-1:0]      mem_raddr;
  logic [IdxW-1:0]      rd_idx;
  logic [RowBits-1:0]   rd_row;

  // Fields of the row just read.
  logic [PID_BITS-1:0]  rd_pid;
  logic [PrioW-1:0]     rd_prio;
  logic signed [CB-1:0] rd_credit;
  logic [HoldW-1:0]     rd_hold;

  // Shared credit arithmetic.
  logic signed [CB-1:0] scan_base;
  logic [CB:0]          scan_sum;
  logic signed [CB-1:0] sat_credit;
  logic                 take;
  logic signed [CB-1:0] tick_credit;
  logic                 tick_resched;
  logic                 pid_match;
  logic                 scan_last;
  logic [HoldW-1:0]     hold_dec;
  logic [HoldW-1:0]     hold_inc;

  cpts_slot_ram #(
    .SLOTS    (SLOTS),
    .ROW_BITS (RowBits),
    .INIT_ROW0(InitRow0)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .raddr_o(rd_idx),
    .rdata_o(rd_row)
  );

  assign rd_pid    = rd_row[PrioLo-1:0];
  assign rd_prio   = rd_row[CredLo-1:PrioLo];
  assign rd_credit = rd_row[HoldLo-1:CredLo];
  assign rd_hold   = rd_row[RowBits-1:HoldLo];

  assign hold_dec = (rd_hold == '0) ? rd_hold : rd_hold - 1'b1;
  assign hold_inc = (rd_hold == '1) ? rd_hold : rd_hold + 1'b1;

  // A reschedule first zeroes the running slot's credit, then adds each occupied
  // slot's priority with saturation at the positive bound. The running slot is
  // zeroed on the fly as the scan passes it.
  assign scan_base  = (rd_idx == run_q) ? '0 : rd_credit;
  assign scan_sum   = {scan_base[CB-1], scan_base} + (CB+1)'(rd_prio);
  assign sat_credit = (!scan_sum[CB] && scan_sum[CB-1]) ? CreditMax : scan_sum[CB-1:0];

  // The first runnable slot with the greatest non-negative credit wins.
  assign take = valid_q[rd_idx] && !blocked_q[rd_idx] && !sat_credit[CB-1] &&
                (!found_q || (sat_credit > best_q));

  assign tick_credit  = (rd_credit == CreditMin) ? rd_credit : rd_credit - 1'b1;
  assign tick_resched = (tick_credit[CB-1] || (tick_credit == '0)) && (rd_hold == '0);

  assign pid_match = valid_q[rd_idx] && (rd_pid == pid_q);
  assign scan_last = (rd_idx == LastSlot);

  always_comb begin
    mem_raddr = run_q;
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = rd_row;
    case (state_q)
      S_SCAN_START: begin
        mem_raddr = '0;
      end
      S_SCAN: begin
        mem_raddr = idx_q;
        case (mode_q)
          M_FREE: begin
            if (!valid_q[rd_idx]) begin
              mem_we    = 1'b1;
              mem_wdata = {{HoldW{1'b0}}, CB'(prio_q), prio_q, pid_q};
            end
          end
          M_FIND: begin
            if (pid_match && (func_q == FN_BLOCK)) begin
              mem_we    = 1'b1;
              mem_wdata = {hold_dec, rd_row[HoldLo-1:0]};
            end
          end
          M_SCHED: begin
            if (valid_q[rd_idx]) begin
              mem_we    = 1'b1;
              mem_wdata = {rd_hold, sat_credit, rd_row[CredLo-1:0]};
            end
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      S_ROW_OP: begin
        case (func_q)
          FN_TICK: begin
            mem_we    = valid_q[run_q];
            mem_wdata = {rd_hold, tick_credit, rd_row[CredLo-1:0]};
          end
          FN_HOLD_UP: begin
            mem_we    = 1'b1;
            mem_wdata = {hold_inc, rd_row[HoldLo-1:0]};
          end
          FN_HOLD_DOWN: begin
            mem_we    = 1'b1;
            mem_wdata = {hold_dec, rd_row[HoldLo-1:0]};
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      S_PICK_RD: begin
        mem_raddr = pick_q;
      end
      S_PICK_WR: begin
        // The chosen slot restarts from its own priority; an empty slot 0 is left alone.
        mem_we    = valid_q[pick_q];
        mem_waddr = pick_q;
        mem_wdata = {rd_hold, CB'(rd_prio), rd_row[CredLo-1:0]};
      end
      default: begin
        mem_raddr = run_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_FREE;
      func_q      <= FN_ADD;
      status_q    <= STS_OK;
      run_q       <= '0;
      before_q    <= '0;
      idx_q       <= '0;
      pick_q      <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      valid_q     <= SLOTS'(1);
      blocked_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // A result leaving while the next one is ready is handled in S_FINAL.
      if (out_valid_q && m_axis_tready_i && (state_q != S_FINAL)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            func_q   <= func_e'(s_axis_tuser_i);
            status_q <= STS_OK;
            before_q <= run_q;
            case (func_e'(s_axis_tuser_i))
              FN_ADD: begin
                mode_q  <= M_FREE;
                state_q <= S_SCAN_START;
              end
              FN_REMOVE, FN_BLOCK, FN_UNBLOCK: begin
                mode_q  <= M_FIND;
                state_q <= S_SCAN_START;
              end
              FN_SCHEDULE: begin
                mode_q  <= M_SCHED;
                state_q <= S_SCAN_START;
              end
              default: begin
                state_q <= S_ROW_RD;
              end
            endcase
          end
        end
        S_SCAN_START: begin
          idx_q   <= IdxW'(1);
          found_q <= 1'b0;
          best_q  <= '0;
          pick_q  <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          idx_q <= (idx_q == LastSlot) ? '0 : idx_q + 1'b1;
          case (mode_q)
            M_FREE: begin
              if (!valid_q[rd_idx]) begin
                valid_q[rd_idx]   <= 1'b1;
                blocked_q[rd_idx] <= 1'b0;
                state_q           <= S_FINAL_RD;
              end else if (scan_last) begin
                status_q <= STS_FULL;
                state_q  <= S_FINAL_RD;
              end
            end
            M_FIND: begin
              if (pid_match) begin
                case (func_q)
                  FN_REMOVE: begin
                    valid_q[rd_idx] <= 1'b0;
                    state_q         <= S_FINAL_RD;
                  end
                  FN_BLOCK: begin
                    blocked_q[rd_idx] <= 1'b1;
                    mode_q            <= M_SCHED;
                    state_q           <= S_SCAN_START;
                  end
                  default: begin
                    blocked_q[rd_idx] <= 1'b0;
                    state_q           <= S_FINAL_RD;
                  end
                endcase
              end else if (scan_last) begin
                // A block of an unknown task still reschedules.
                status_q <= STS_NOT_FOUND;
                if (func_q == FN_BLOCK) begin
                  mode_q  <= M_SCHED;
                  state_q <= S_SCAN_START;
                end else begin
                  state_q <= S_FINAL_RD;
                end
              end
            end
            default: begin
              if (take) begin
                found_q <= 1'b1;
                best_q  <= sat_credit;
                pick_q  <= rd_idx;
              end
              if (scan_last) begin
                state_q <= S_PICK_RD;
              end
            end
          endcase
        end
        S_ROW_RD: begin
          state_q <= S_ROW_OP;
        end
        S_ROW_OP: begin
          // Ticking an empty running slot reschedules at once.
          if ((func_q == FN_TICK) && (!valid_q[run_q] || tick_resched)) begin
            mode_q  <= M_SCHED;
            state_q <= S_SCAN_START;
          end else begin
            state_q <= S_FINAL_RD;
          end
        end
        S_PICK_RD: begin
          state_q <= S_PICK_WR;
        end
        S_PICK_WR: begin
          run_q   <= pick_q;
          state_q <= S_FINAL_RD;
        end
        S_FINAL_RD: begin
          state_q <= S_FINAL;
        end
        S_FINAL: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {{(OutDataW - SlotOutW - PidInW - 1 - StatusW){1'b0}},
                            status_q,
                            (run_q != before_q),
                            valid_q[run_q] ? PidInW'(rd_pid) : {PidInW{1'b0}},
                            SlotOutW'(run_q)};
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload registers; they need no reset.
  logic [PID_BITS-1:0] pid_in;
  assign pid_in = PID_BITS'(s_axis_tdata_i[PidInW-1:0]);

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && s_axis_tvalid_i) begin
      pid_q  <= pid_in;
      prio_q <= s_axis_tdata_i[PidInW +: PrioW];
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> sim/cpts_sched_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the scheduler. It keeps its own copy of the slot
// table, computes the result of every accepted request and compares each
// accepted result with the oldest outstanding one.
module cpts_sched_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic [cpts_pkg::InDataW-1:0]  req_data_i,
  input  logic [cpts_pkg::FuncW-1:0]    req_func_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [cpts_pkg::OutDataW-1:0] res_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o,
  output int unsigned                   full_hits_o,
  output int unsigned                   switch_hits_o
);
  import cpts_pkg::*;

  localparam int unsigned SlotCount = SlotsDef;
  localparam longint CreditMax = (longint'(1) <<< (CreditBitsDef - 1)) - 1;
  localparam longint CreditMin = -CreditMax - 1;

  typedef struct packed {
    logic [SlotOutW-1:0] slot;
    logic [15:0]         pid;
    logic                switched;
    status_e             status;
  } sched_result_t;

  logic        occ    [SlotCount];
  logic        blk    [SlotCount];
  logic [15:0] tag    [SlotCount];
  logic [7:0]  weight [SlotCount];
  longint      credit [SlotCount];
  logic [7:0]  hold   [SlotCount];
  int unsigned cur;

  sched_result_t result_q[$];
  int unsigned   fails, checked, full_hits, switch_hits;

  function automatic void clear_table();
    for (int i = 0; i < SlotCount; i++) begin
      occ[i]    = 1'b0;
      blk[i]    = 1'b0;
      tag[i]    = '0;
      weight[i] = '0;
      credit[i] = 0;
      hold[i]   = '0;
    end
    occ[0]    = 1'b1;
    weight[0] = 8'd1;
    cur       = 0;
  endfunction

  // Earliest occupied slot that holds this identifier, -1 if none.
  function automatic int lookup(logic [15:0] id);
    int hit = -1;
    for (int i = SlotCount - 1; i >= 0; i--)
      if (occ[i] && tag[i] == id) hit = i;
    return hit;
  endfunction

  function automatic void pick_next();
    longint      best = -1;
    int unsigned sel  = 0;
    credit[cur] = 0;
    for (int unsigned i = 0; i < SlotCount; i++) begin
      if (occ[i]) begin
        if (credit[i] > CreditMax - longint'(weight[i])) credit[i] = CreditMax;
        else credit[i] = credit[i] + longint'(weight[i]);
        if (!blk[i] && credit[i] > best) begin
          best = credit[i];
          sel  = i;
        end
      end
    end
    if (occ[sel]) credit[sel] = longint'(weight[sel]);
    cur = sel;
  endfunction

  function automatic sched_result_t apply_request(func_e fn, logic [15:0] id,
                                                  logic [7:0] w);
    sched_result_t r;
    int            s;
    int unsigned   prev;
    prev     = cur;
    r.status = STS_OK;
    case (fn)
      FN_ADD: begin
        s = -1;
        for (int i = SlotCount - 1; i >= 0; i--)
          if (!occ[i]) s = i;
        if (s < 0) begin
          r.status = STS_FULL;
        end else begin
          occ[s]    = 1'b1;
          blk[s]    = 1'b0;
          tag[s]    = id;
          weight[s] = w;
          credit[s] = longint'(w);
          hold[s]   = '0;
        end
      end
      FN_REMOVE: begin
        s = lookup(id);
        if (s < 0) r.status = STS_NOT_FOUND;
        else occ[s] = 1'b0;
      end
      FN_BLOCK: begin
        s = lookup(id);
        if (s < 0) begin
          r.status = STS_NOT_FOUND;
        end else begin
          blk[s] = 1'b1;
          if (hold[s] != 0) hold[s] = hold[s] - 8'd1;
        end
        pick_next();
      end
      FN_UNBLOCK: begin
        s = lookup(id);
        if (s < 0) r.status = STS_NOT_FOUND;
        else blk[s] = 1'b0;
      end
      FN_TICK: begin
        if (!occ[cur]) begin
          pick_next();
        end else begin
          if (credit[cur] > CreditMin) credit[cur] = credit[cur] - 1;
          if (credit[cur] <= 0 && hold[cur] == 0) pick_next();
        end
      end
      FN_SCHEDULE: pick_next();
      FN_HOLD_UP: if (hold[cur] != 8'hFF) hold[cur] = hold[cur] + 8'd1;
      default: if (hold[cur] != 0) hold[cur] = hold[cur] - 8'd1;
    endcase
    r.slot     = cur[SlotOutW-1:0];
    r.pid      = occ[cur] ? tag[cur] : 16'h0;
    r.switched = (cur != prev);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    logic [SlotOutW-1:0] got_slot;
    logic [15:0]         got_pid;
    logic                got_sw;
    logic [1:0]          got_status;
    if (!rst_ni) begin
      clear_table();
      result_q.delete();
      fails       = 0;
      checked     = 0;
      full_hits   = 0;
      switch_hits = 0;
    end else begin
      // The request is predicted first; a result never leaves in the
      // same cycle its request enters.
      if (req_valid_i && req_ready_i) begin
        want = apply_request(func_e'(req_func_i), req_data_i[15:0], req_data_i[23:16]);
        result_q.push_back(want);
        if (want.status == STS_FULL) full_hits++;
        if (want.switched) switch_hits++;
      end
      if (res_valid_i && res_ready_i) begin
        got_slot   = res_data_i[5:0];
        got_pid    = res_data_i[21:6];
        got_sw     = res_data_i[22];
        got_status = res_data_i[24:23];
        if (result_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: result slot %0d pid %h with no request outstanding",
                     $realtime, got_slot, got_pid);
          fails++;
        end else begin
          want = result_q.pop_front();
          checked++;
          if (got_slot !== want.slot || got_pid !== want.pid ||
              got_sw !== want.switched || got_status !== want.status) begin
            if (fails < 10)
              $display({"%0t: mismatch, expected slot %0d pid %h switched %0b status %0d,",
                        " got slot %0d pid %h switched %0b status %0d"},
                       $realtime, want.slot, want.pid, want.switched, want.status,
                       got_slot, got_pid, got_sw, got_status);
            fails++;
          end
        end
      end
    end
    fail_count_o  <= fails;
    pending_o     <= result_q.size();
    checked_o     <= checked;
    full_hits_o   <= full_hits;
    switch_hits_o <= switch_hits;
  end

endmodule

>>> sim/credit_priority_task_scheduler_top_test.sv
`timescale 1ns / 100ps

// Stimulus side of the scheduler test. The checker beside the block predicts
// and compares; this module only produces requests, applies back-pressure on
// the result channel and decides the verdict from the checker's counts.
module credit_priority_task_scheduler_top_test;
  import cpts_pkg::*;

  // Slowest request (block) takes about two scans of the table.
  localparam int unsigned EndSettle  = 2 * SlotsDef + 16;
  // This limit lies far above the slowest correct run.
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned PoolSize   = 40;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                s_valid  = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data   = '0;
  logic [FuncW-1:0]    s_user   = '0;
  logic                m_valid;
  logic                m_ready  = 1'b0;
  logic [OutDataW-1:0] m_data;

  int unsigned fail_count, pending, checked, full_hits, switch_hits;
  int unsigned cycles = 0;
  int unsigned sent_per_func [8];
  logic [15:0] pid_pool [PoolSize];

  // Idling switches, changed per phase so that some stretches run flat out.
  logic gaps_on   = 1'b1;
  logic stalls_on = 1'b1;
  int unsigned stall_left = 0;

  always #2 clk_i = ~clk_i;

  credit_priority_task_scheduler_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  cpts_sched_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_valid),
    .req_ready_i   (s_ready),
    .req_data_i    (s_data),
    .req_func_i    (s_user),
    .res_valid_i   (m_valid),
    .res_ready_i   (m_ready),
    .res_data_i    (m_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_hits_o   (full_hits),
    .switch_hits_o (switch_hits)
  );

  // Most idle stretches come from the low range; now and then a long one.
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 48);
  endfunction

  // Result side back-pressure. While stalls are enabled the ready line drops
  // at random moments for a random number of cycles.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_ready    <= 1'b0;
    end else if (!stalls_on || $urandom_range(0, 3) != 0) begin
      m_ready <= 1'b1;
    end else begin
      m_ready    <= 1'b0;
      stall_left <= gap_len() - 1;
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("credit_priority_task_scheduler_top_test: done, errors");
      $finish;
    end
  end

  // Places one request on the channel and waits for its handshake. The valid
  // line stays high afterwards, so back-to-back requests need no extra edge.
  // A random gap may follow, during which the valid line is low.
  task automatic issue(func_e fn, logic [15:0] id, logic [7:0] w);
    int unsigned n;
    s_valid <= 1'b1;
    s_user  <= fn;
    s_data  <= {w, id};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sent_per_func[fn]++;
    n = (gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (n != 0) begin
      s_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Holds the request channel idle until every outstanding result is back.
  // The extra edge lets the checker's count catch up with the last request.
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly identifiers from a small pool, so that remove, block and unblock
  // usually hit a live task and adds create duplicates; the rest are random
  // values that will almost never be found.
  function automatic logic [15:0] pick_pid();
    if ($urandom_range(0, 6) == 0) return 16'($urandom);
    return pid_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  // The first phase is add-heavy so that the table fills up and the full
  // status shows; the last one removes more often than it adds.
  function automatic func_e pick_func(int unsigned phase);
    int unsigned r;
    int unsigned add_cut, remove_cut;
    r = $urandom_range(0, 99);
    case (phase)
      0: begin
        add_cut    = 70;
        remove_cut = 74;
      end
      3: begin
        add_cut    = 10;
        remove_cut = 40;
      end
      default: begin
        add_cut    = 20;
        remove_cut = 34;
      end
    endcase
    if (r < add_cut) return FN_ADD;
    if (r < remove_cut) return FN_REMOVE;
    r = $urandom_range(0, 99);
    if (r < 18) return FN_BLOCK;
    if (r < 34) return FN_UNBLOCK;
    if (r < 64) return FN_TICK;
    if (r < 80) return FN_SCHEDULE;
    if (r < 90) return FN_HOLD_UP;
    return FN_HOLD_DOWN;
  endfunction

  initial begin
    pid_pool[0] = 16'h0000;
    pid_pool[1] = 16'hFFFF;
    for (int i = 2; i < PoolSize; i++) pid_pool[i] = 16'($urandom);
    for (int i = 0; i < 8; i++) sent_per_func[i] = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. Only slot 0 is live at first: a tick drives its
    // credit negative and reschedules, and hold down at zero must stay zero.
    issue(FN_TICK, 16'h0000, 8'h00);
    issue(FN_HOLD_DOWN, 16'h0000, 8'h00);
    issue(FN_SCHEDULE, 16'h0000, 8'h00);
    // Extreme identifiers and priorities, including priority zero and
    // identifiers that already exist in the table.
    issue(FN_ADD, 16'hFFFF, 8'hFF);
    issue(FN_ADD, 16'h0000, 8'h00);
    issue(FN_ADD, 16'h1234, 8'h01);
    issue(FN_ADD, 16'hFFFF, 8'h07);
    issue(FN_SCHEDULE, 16'h0000, 8'h00);
    // Hold up twice on the running task, then tick it while it is held.
    issue(FN_HOLD_UP, 16'h0000, 8'h00);
    issue(FN_HOLD_UP, 16'h0000, 8'h00);
    issue(FN_TICK, 16'h0000, 8'h00);
    issue(FN_TICK, 16'h0000, 8'h00);
    issue(FN_HOLD_DOWN, 16'h0000, 8'h00);
    issue(FN_BLOCK, 16'hFFFF, 8'h00);
    issue(FN_UNBLOCK, 16'hFFFF, 8'h00);
    // Unknown identifier: block still reschedules, the others do nothing.
    issue(FN_BLOCK, 16'hBEEF, 8'h00);
    issue(FN_UNBLOCK, 16'hBEEF, 8'h00);
    issue(FN_REMOVE, 16'hBEEF, 8'h00);
    // Empty the table, possibly under the running task, then tick so that
    // an empty running slot forces a reschedule that may land on empty slot 0.
    issue(FN_REMOVE, 16'h0000, 8'h00);
    issue(FN_SCHEDULE, 16'h0000, 8'h00);
    issue(FN_REMOVE, 16'h0000, 8'h00);
    issue(FN_REMOVE, 16'hFFFF, 8'h00);
    issue(FN_REMOVE, 16'hFFFF, 8'h00);
    issue(FN_REMOVE, 16'h1234, 8'h00);
    issue(FN_TICK, 16'h0000, 8'h00);
    issue(FN_ADD, 16'h5A5A, 8'hA5);

    // Let everything come back before the random part starts.
    drain();

    for (int unsigned phase = 0; phase < 4; phase++) begin
      gaps_on   = (phase != 2);
      stalls_on = (phase != 3);
      for (int k = 0; k < (phase == 0 ? 110 : 35); k++)
        issue(pick_func(phase), pick_pid(), 8'($urandom_range(0, 255)));
      drain();
      if (phase == 1) begin
        // Push the running task's hold past its top, then step it down and
        // let block and ticks work against the value just below the top.
        gaps_on = 1'b0;
        repeat (258) issue(FN_HOLD_UP, pick_pid(), 8'($urandom));
        issue(FN_HOLD_DOWN, 16'h0000, 8'h00);
        repeat (4) issue(FN_TICK, 16'h0000, 8'h00);
        issue(FN_BLOCK, pick_pid(), 8'h00);
        drain();
      end
    end

    // Anything a request started still has time to show up as an extra result.
    stalls_on = 1'b0;
    repeat (EndSettle) @(posedge clk_i);

    $display({"sent %0d add, %0d remove, %0d block, %0d unblock, %0d tick,",
              " %0d schedule, %0d/%0d hold"},
             sent_per_func[FN_ADD], sent_per_func[FN_REMOVE], sent_per_func[FN_BLOCK],
             sent_per_func[FN_UNBLOCK], sent_per_func[FN_TICK], sent_per_func[FN_SCHEDULE],
             sent_per_func[FN_HOLD_UP], sent_per_func[FN_HOLD_DOWN]);
    $display("%0d results checked, %0d with table full, %0d task switches, %0d failures",
             checked, full_hits, switch_hits, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("credit_priority_task_scheduler_top_test: done, clean");
    end else begin
      $display("credit_priority_task_scheduler_top_test: done, errors");
    end
    $finish;
  end

endmodule

>>> credit_priority_task_scheduler_top.f
design/cpts_pkg.sv
design/cpts_slot_ram.sv
design/credit_priority_task_scheduler_top.sv
sim/cpts_sched_checker.sv
sim/credit_priority_task_scheduler_top_test.sv
